[hdl/qacpm_pkg.sv]
// Package with the types, constants and saturation helpers of the attitude controller.
package qacpm_pkg;

  localparam int MOTORS      = 4;
  localparam int AXES        = 3;
  localparam int MUL_DIGIT   = 4;
  localparam int MUL_STEPS   = 32 / MUL_DIGIT;
  localparam int ADDR_W      = 5;
  localparam logic [16:0] Q_ONE = 17'd65536;
  localparam logic [31:0] STICK_SCALE = 32'd19661;

  // Bit j set means axis j enters that motor's mix with a minus sign.
  localparam logic [2:0] MIX_NEG [MOTORS] = '{3'b001, 3'b100, 3'b010, 3'b111};

  typedef enum logic [2:0] {
    REG_ANGLE_GAIN,
    REG_RATE_P_GAIN,
    REG_RATE_I_GAIN,
    REG_RATE_D_GAIN,
    REG_IDLE_THRESHOLD,
    REG_OFFSET_WEIGHT,
    REG_PWM_MIN,
    REG_PWM_MAX
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STICK,
    ST_ANGLE,
    ST_PGAIN,
    ST_DGAIN,
    ST_IGAIN,
    ST_INTEG,
    ST_CTL,
    ST_MIX,
    ST_EMA_X,
    ST_EMA_O,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [16:0]        throttle;
    logic signed [31:0] stick_roll;
    logic signed [31:0] stick_pitch;
    logic signed [31:0] stick_yaw;
    logic signed [31:0] angle_a;
    logic signed [31:0] angle_b;
    logic signed [31:0] angle_c;
    logic signed [31:0] rate_a;
    logic signed [31:0] rate_b;
    logic signed [31:0] rate_c;
  } tick_t;

  typedef struct packed {
    logic [15:0] motor0_pwm;
    logic [15:0] motor1_pwm;
    logic [15:0] motor2_pwm;
    logic [15:0] motor3_pwm;
    logic        idle;
  } motor_t;

  typedef struct packed {
    logic [31:0] angle_gain;
    logic [31:0] rate_p_gain;
    logic [31:0] rate_i_gain;
    logic [31:0] rate_d_gain;
    logic [16:0] idle_threshold;
    logic [16:0] offset_weight;
    logic [15:0] pwm_min;
    logic [15:0] pwm_max;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(66'(a) - 66'(b));
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

endpackage

[hdl/qacpm_mul.sv]
// Digit-serial signed by unsigned multiplier, four multiplier bits per cycle.
module qacpm_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] a,
  input  logic        [31:0] b,
  output logic               done,
  output logic signed [65:0] prod
);

  logic               busy;
  logic [2:0]         cnt;
  logic signed [38:0] acc;
  logic [31:0]        lo;
  logic signed [33:0] mcand;
  logic signed [38:0] sum;
  logic [70:0]        whole;

  assign sum   = acc + mcand * $signed({1'b0, lo[qacpm_pkg::MUL_DIGIT-1:0]});
  assign whole = {acc, lo};
  assign prod  = $signed(whole[65:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(qacpm_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      lo    <= b;
      mcand <= a;
    end else if (busy) begin
      acc <= sum >>> qacpm_pkg::MUL_DIGIT;
      lo  <= {sum[qacpm_pkg::MUL_DIGIT-1:0], lo[31:qacpm_pkg::MUL_DIGIT]};
    end
  end

endmodule

[hdl/qacpm_cfg.sv]
// APB register file holding the controller gains, thresholds and pulse width range.
module qacpm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qacpm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output qacpm_pkg::cfg_t                cfg
);

  qacpm_pkg::reg_idx_t idx;

  assign idx    = qacpm_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_gain     <= 32'd285212672;
      cfg.rate_p_gain    <= 32'd53687;
      cfg.rate_i_gain    <= 32'd604;
      cfg.rate_d_gain    <= 32'd251658;
      cfg.idle_threshold <= 17'd3277;
      cfg.offset_weight  <= 17'd3277;
      cfg.pwm_min        <= 16'd1000;
      cfg.pwm_max        <= 16'd2000;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        qacpm_pkg::REG_ANGLE_GAIN:     cfg.angle_gain     <= pwdata;
        qacpm_pkg::REG_RATE_P_GAIN:    cfg.rate_p_gain    <= pwdata;
        qacpm_pkg::REG_RATE_I_GAIN:    cfg.rate_i_gain    <= pwdata;
        qacpm_pkg::REG_RATE_D_GAIN:    cfg.rate_d_gain    <= pwdata;
        qacpm_pkg::REG_IDLE_THRESHOLD: cfg.idle_threshold <= pwdata[16:0];
        qacpm_pkg::REG_OFFSET_WEIGHT:  cfg.offset_weight  <= pwdata[16:0];
        qacpm_pkg::REG_PWM_MIN:        cfg.pwm_min        <= pwdata[15:0];
        qacpm_pkg::REG_PWM_MAX:        cfg.pwm_max        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qacpm_pkg::REG_ANGLE_GAIN:     prdata = cfg.angle_gain;
      qacpm_pkg::REG_RATE_P_GAIN:    prdata = cfg.rate_p_gain;
      qacpm_pkg::REG_RATE_I_GAIN:    prdata = cfg.rate_i_gain;
      qacpm_pkg::REG_RATE_D_GAIN:    prdata = cfg.rate_d_gain;
      qacpm_pkg::REG_IDLE_THRESHOLD: prdata = {15'd0, cfg.idle_threshold};
      qacpm_pkg::REG_OFFSET_WEIGHT:  prdata = {15'd0, cfg.offset_weight};
      qacpm_pkg::REG_PWM_MIN:        prdata = {16'd0, cfg.pwm_min};
      qacpm_pkg::REG_PWM_MAX:        prdata = {16'd0, cfg.pwm_max};
      default:                       prdata = '0;
    endcase
  end

endmodule

[hdl/quad_attitude_cascade_pid_mixer.sv]
// Top level: sequencer and datapath of the cascaded attitude/rate PID with X-quad mixer.
// Every multiplication runs on one shared digit-serial multiplier.
// When idle, a transaction also runs offset learning on the angle, rate and stick offsets.
// One transaction is processed at a time, so a new one is accepted only after the last has finished.
// A finished result waits in the output register while the next transaction is accepted.
// Synchronous reset clears the controller state and offsets and restores register defaults.
module quad_attitude_cascade_pid_mixer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tick_valid,
  output logic                         tick_ready,
  input  qacpm_pkg::tick_t             tick,
  output logic                         motor_valid,
  input  logic                         motor_ready,
  output qacpm_pkg::motor_t            motor,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qacpm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  qacpm_pkg::cfg_t   cfg;
  qacpm_pkg::state_t state, state_next;
  qacpm_pkg::tick_t  tk;

  logic               mul_start, mul_done, issued;
  logic signed [33:0] mul_a;
  logic [31:0]        mul_b;
  logic signed [65:0] prod;

  logic [1:0] k, mot, grp, elem;
  logic signed [31:0] integ_st [qacpm_pkg::AXES];
  logic signed [31:0] prev_err [qacpm_pkg::AXES];
  logic signed [31:0] aoff [qacpm_pkg::AXES];
  logic signed [31:0] roff [qacpm_pkg::AXES];
  logic signed [31:0] soff [qacpm_pkg::AXES];
  logic signed [31:0] ctl [qacpm_pkg::AXES];
  logic [15:0]        pwm [qacpm_pkg::MOTORS];
  logic signed [31:0] t_r, tgt_r, err_r, p_r, d_r, gi_r, integ_r;
  logic signed [65:0] pa_r;

  logic signed [31:0] stick_in [qacpm_pkg::AXES];
  logic signed [31:0] angle_in [qacpm_pkg::AXES];
  logic signed [31:0] rate_in [qacpm_pkg::AXES];
  logic [1:0]         ai;
  logic               idle_w;
  logic [16:0]        weff, wcomp;
  logic signed [16:0] span;
  logic signed [35:0] mix_sum;
  logic signed [36:0] m_raw;
  logic [16:0]        m_val;
  logic signed [31:0] err_w, integ_w, lim_w, x_sel, o_sel;
  logic signed [32:0] ap;
  logic signed [65:0] ema_sum;
  logic               mul_state;

  qacpm_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  qacpm_mul u_mul (
    .clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b), .done(mul_done), .prod
  );

  assign stick_in = '{tk.stick_roll, tk.stick_pitch, tk.stick_yaw};
  assign angle_in = '{tk.angle_a, tk.angle_b, tk.angle_c};
  assign rate_in  = '{tk.rate_a, tk.rate_b, tk.rate_c};

  always_comb begin
    unique case (k)
      2'd0:    ai = 2'd1;
      2'd1:    ai = 2'd0;
      default: ai = 2'd2;
    endcase
  end

  assign idle_w = tk.throttle < cfg.idle_threshold;
  assign weff   = (cfg.offset_weight > qacpm_pkg::Q_ONE) ? qacpm_pkg::Q_ONE : cfg.offset_weight;
  assign wcomp  = qacpm_pkg::Q_ONE - weff;
  assign span   = $signed({1'b0, cfg.pwm_max}) - $signed({1'b0, cfg.pwm_min});

  assign err_w = qacpm_pkg::sub_sat(tgt_r, qacpm_pkg::sub_sat(rate_in[k], roff[k]));

  always_comb begin
    mix_sum = '0;
    for (int j = 0; j < qacpm_pkg::AXES; j++) begin
      if (qacpm_pkg::MIX_NEG[mot][j]) begin
        mix_sum = mix_sum - 36'(ctl[j]);
      end else begin
        mix_sum = mix_sum + 36'(ctl[j]);
      end
    end
    m_raw = $signed({20'd0, tk.throttle}) + 37'(mix_sum >>> 1);
    if (idle_w || m_raw < 0) begin
      m_val = '0;
    end else if (m_raw > 37'sd65536) begin
      m_val = qacpm_pkg::Q_ONE;
    end else begin
      m_val = m_raw[16:0];
    end
  end

  assign ap      = (p_r < 0) ? -33'(p_r) : 33'(p_r);
  assign lim_w   = qacpm_pkg::sat32(66'(ap) + 66'(ap));
  assign integ_w = qacpm_pkg::add_sat(integ_st[k], gi_r);

  always_comb begin
    unique case (grp)
      2'd0: begin
        x_sel = angle_in[elem];
        o_sel = aoff[elem];
      end
      2'd1: begin
        x_sel = rate_in[elem];
        o_sel = roff[elem];
      end
      default: begin
        x_sel = stick_in[elem];
        o_sel = soff[elem];
      end
    endcase
  end

  assign ema_sum = pa_r + prod;

  always_comb begin
    state_next = state;
    unique case (state)
      qacpm_pkg::ST_IDLE:  if (tick_valid) state_next = qacpm_pkg::ST_STICK;
      qacpm_pkg::ST_STICK: if (mul_done) state_next = qacpm_pkg::ST_ANGLE;
      qacpm_pkg::ST_ANGLE: if (mul_done) state_next = qacpm_pkg::ST_PGAIN;
      qacpm_pkg::ST_PGAIN: if (mul_done) state_next = qacpm_pkg::ST_DGAIN;
      qacpm_pkg::ST_DGAIN: if (mul_done) state_next = qacpm_pkg::ST_IGAIN;
      qacpm_pkg::ST_IGAIN: if (mul_done) state_next = qacpm_pkg::ST_INTEG;
      qacpm_pkg::ST_INTEG: state_next = qacpm_pkg::ST_CTL;
      qacpm_pkg::ST_CTL: begin
        state_next = (k == 2'd2) ? qacpm_pkg::ST_MIX : qacpm_pkg::ST_STICK;
      end
      qacpm_pkg::ST_MIX: begin
        if (mul_done && mot == 2'(qacpm_pkg::MOTORS - 1)) begin
          state_next = idle_w ? qacpm_pkg::ST_EMA_X : qacpm_pkg::ST_DONE;
        end
      end
      qacpm_pkg::ST_EMA_X: if (mul_done) state_next = qacpm_pkg::ST_EMA_O;
      qacpm_pkg::ST_EMA_O: begin
        if (mul_done) begin
          state_next = (grp == 2'd2 && elem == 2'd2) ? qacpm_pkg::ST_DONE
                                                     : qacpm_pkg::ST_EMA_X;
        end
      end
      qacpm_pkg::ST_DONE: if (!motor_valid || motor_ready) state_next = qacpm_pkg::ST_IDLE;
      default: state_next = qacpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_state = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      qacpm_pkg::ST_STICK: begin
        mul_a = 34'(qacpm_pkg::sub_sat(stick_in[k], soff[k]));
        mul_b = qacpm_pkg::STICK_SCALE;
      end
      qacpm_pkg::ST_ANGLE: begin
        mul_a = 34'(qacpm_pkg::sub_sat(t_r, qacpm_pkg::sub_sat(angle_in[ai], aoff[ai])));
        mul_b = cfg.angle_gain;
      end
      qacpm_pkg::ST_PGAIN: begin
        mul_a = 34'(err_w);
        mul_b = cfg.rate_p_gain;
      end
      qacpm_pkg::ST_DGAIN: begin
        mul_a = 34'(qacpm_pkg::sub_sat(err_r, prev_err[k]));
        mul_b = cfg.rate_d_gain;
      end
      qacpm_pkg::ST_IGAIN: begin
        mul_a = 34'(err_r);
        mul_b = cfg.rate_i_gain;
      end
      qacpm_pkg::ST_MIX: begin
        mul_a = 34'(span);
        mul_b = {15'd0, m_val};
      end
      qacpm_pkg::ST_EMA_X: begin
        mul_a = 34'(x_sel);
        mul_b = {15'd0, weff};
      end
      qacpm_pkg::ST_EMA_O: begin
        mul_a = 34'(o_sel);
        mul_b = {15'd0, wcomp};
      end
      default: mul_state = 1'b0;
    endcase
    mul_start  = mul_state && !issued;
    tick_ready = (state == qacpm_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= qacpm_pkg::ST_IDLE;
      issued      <= 1'b0;
      motor_valid <= 1'b0;
      k           <= '0;
      mot         <= '0;
      grp         <= '0;
      elem        <= '0;
      for (int i = 0; i < qacpm_pkg::AXES; i++) begin
        integ_st[i] <= '0;
        prev_err[i] <= '0;
        aoff[i]     <= '0;
        roff[i]     <= '0;
        soff[i]     <= '0;
      end
    end else begin
      state <= state_next;
      if (mul_start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end
      if (state == qacpm_pkg::ST_DONE && (!motor_valid || motor_ready)) begin
        motor_valid <= 1'b1;
      end else if (motor_valid && motor_ready) begin
        motor_valid <= 1'b0;
      end
      unique case (state)
        qacpm_pkg::ST_IDLE: begin
          k    <= '0;
          mot  <= '0;
          grp  <= '0;
          elem <= '0;
        end
        qacpm_pkg::ST_INTEG: begin
          if (integ_w > lim_w) begin
            integ_st[k] <= lim_w;
          end else if (integ_w < -lim_w) begin
            integ_st[k] <= -lim_w;
          end else begin
            integ_st[k] <= integ_w;
          end
        end
        qacpm_pkg::ST_CTL: begin
          prev_err[k] <= err_r;
          k           <= k + 2'd1;
        end
        qacpm_pkg::ST_MIX: begin
          if (mul_done) begin
            mot <= mot + 2'd1;
            if (mot == 2'(qacpm_pkg::MOTORS - 1) && idle_w) begin
              for (int i = 0; i < qacpm_pkg::AXES; i++) integ_st[i] <= '0;
            end
          end
        end
        qacpm_pkg::ST_EMA_O: begin
          if (mul_done) begin
            unique case (grp)
              2'd0:    aoff[elem] <= qacpm_pkg::sat32(ema_sum >>> 16);
              2'd1:    roff[elem] <= qacpm_pkg::sat32(ema_sum >>> 16);
              default: soff[elem] <= qacpm_pkg::sat32(ema_sum >>> 16);
            endcase
            if (elem == 2'd2) begin
              elem <= '0;
              grp  <= grp + 2'd1;
            end else begin
              elem <= elem + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) tk <= tick;
    if (state == qacpm_pkg::ST_PGAIN && mul_start) err_r <= err_w;
    if (mul_done) begin
      unique case (state)
        qacpm_pkg::ST_STICK: t_r   <= qacpm_pkg::sat32(prod >>> 16);
        qacpm_pkg::ST_ANGLE: tgt_r <= qacpm_pkg::sat32(prod >>> 24);
        qacpm_pkg::ST_PGAIN: p_r   <= qacpm_pkg::sat32(prod >>> 24);
        qacpm_pkg::ST_DGAIN: d_r   <= qacpm_pkg::sat32(prod >>> 24);
        qacpm_pkg::ST_IGAIN: gi_r  <= qacpm_pkg::sat32(prod >>> 24);
        qacpm_pkg::ST_MIX:   pwm[mot] <= cfg.pwm_min + 16'(prod >>> 16);
        qacpm_pkg::ST_EMA_X: pa_r  <= prod;
        default: ;
      endcase
    end
    if (state == qacpm_pkg::ST_INTEG) begin
      if (integ_w > lim_w) begin
        integ_r <= lim_w;
      end else if (integ_w < -lim_w) begin
        integ_r <= -lim_w;
      end else begin
        integ_r <= integ_w;
      end
    end
    if (state == qacpm_pkg::ST_CTL) begin
      ctl[k] <= qacpm_pkg::sat32(66'(p_r) + 66'(integ_r) + 66'(d_r));
    end
    if (state == qacpm_pkg::ST_DONE && (!motor_valid || motor_ready)) begin
      motor.motor0_pwm <= pwm[0];
      motor.motor1_pwm <= pwm[1];
      motor.motor2_pwm <= pwm[2];
      motor.motor3_pwm <= pwm[3];
      motor.idle       <= idle_w;
    end
  end

  a_done_after_issue: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> issued) else $error("Multiplier finished without an issued operation.");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    tick_ready |-> state == qacpm_pkg::ST_IDLE && !issued)
    else $error("Input taken while a transaction is in flight.");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(motor_valid) |-> $past(state) == qacpm_pkg::ST_DONE)
    else $error("Result presented outside the completion step.");

endmodule

[tb/sv/tb_quad_attitude_cascade_pid_mixer.sv]
// Self-checking testbench for the cascaded attitude/rate PID controller with X-quad mixer.
module tb_quad_attitude_cascade_pid_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WD_LIMIT = 20000;
  localparam int SETTLE   = 500;
  localparam int HOLD_LEN = 3000;

  logic clk;
  logic rst;
  logic tick_valid;
  logic tick_ready;
  qacpm_pkg::tick_t tick;
  logic motor_valid;
  logic motor_ready;
  qacpm_pkg::motor_t motor;
  logic psel;
  logic penable;
  logic pwrite;
  logic [qacpm_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  quad_attitude_cascade_pid_mixer uut (
    .clk(clk), .rst(rst),
    .tick_valid(tick_valid), .tick_ready(tick_ready), .tick(tick),
    .motor_valid(motor_valid), .motor_ready(motor_ready), .motor(motor),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  qacpm_pkg::tick_t  tick_q[$];
  qacpm_pkg::motor_t motor_exp_q[$];
  qacpm_pkg::cfg_t   gains;
  int     errors;

  int integ_st[3];
  int prev_err[3];
  int ang_off[3];
  int rate_off[3];
  int stick_off[3];

  localparam int ANGLE_SEL[3] = '{1, 0, 2};
  localparam int MIX_SIGN[qacpm_pkg::MOTORS][3] =
    '{'{-1, 1, 1}, '{1, 1, -1}, '{1, -1, 1}, '{-1, -1, -1}};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int gain_scale(int x, logic [31:0] g);
    return clamp32((longint'(x) * longint'({32'd0, g})) >>> 24);
  endfunction

  function automatic int offset_avg(int o, int x, longint w);
    return clamp32((longint'(x) * w + longint'(o) * (65536 - w)) >>> 16);
  endfunction

  function automatic void motor_predict(qacpm_pkg::tick_t t);
    int stk[3];
    int ang[3];
    int rt[3];
    int ctl[3];
    int s, tg, a, e, target, g, err, p, d, lim, integ;
    longint thr, w, m, span, sum;
    logic idle;
    qacpm_pkg::motor_t r;
    logic [15:0] pwm[qacpm_pkg::MOTORS];
    stk = '{t.stick_roll, t.stick_pitch, t.stick_yaw};
    ang = '{t.angle_a, t.angle_b, t.angle_c};
    rt  = '{t.rate_a, t.rate_b, t.rate_c};
    thr = longint'({47'd0, t.throttle});
    for (int k = 0; k < 3; k++) begin
      s = clamp32(longint'(stk[k]) - stick_off[k]);
      tg = clamp32((longint'(s) * 19661) >>> 16);
      a = clamp32(longint'(ang[ANGLE_SEL[k]]) - ang_off[ANGLE_SEL[k]]);
      e = clamp32(longint'(tg) - a);
      target = gain_scale(e, gains.angle_gain);
      g = clamp32(longint'(rt[k]) - rate_off[k]);
      err = clamp32(longint'(target) - g);
      p = gain_scale(err, gains.rate_p_gain);
      d = gain_scale(clamp32(longint'(err) - prev_err[k]), gains.rate_d_gain);
      lim = clamp32(2 * ((p < 0) ? -longint'(p) : longint'(p)));
      integ = clamp32(longint'(integ_st[k]) + gain_scale(err, gains.rate_i_gain));
      if (integ > lim) integ = lim;
      if (integ < -lim) integ = -lim;
      integ_st[k] = integ;
      ctl[k] = clamp32(longint'(p) + integ + d);
      prev_err[k] = err;
    end
    idle = thr < longint'({47'd0, gains.idle_threshold});
    span = longint'({48'd0, gains.pwm_max}) - longint'({48'd0, gains.pwm_min});
    for (int i = 0; i < qacpm_pkg::MOTORS; i++) begin
      m = 0;
      if (!idle) begin
        sum = MIX_SIGN[i][0] * longint'(ctl[0]) + MIX_SIGN[i][1] * longint'(ctl[1])
            + MIX_SIGN[i][2] * longint'(ctl[2]);
        m = thr + (sum >>> 1);
        if (m > 65536) m = 65536;
        if (m < 0) m = 0;
      end
      pwm[i] = 16'(longint'({48'd0, gains.pwm_min}) + ((span * m) >>> 16));
    end
    r.motor0_pwm = pwm[0];
    r.motor1_pwm = pwm[1];
    r.motor2_pwm = pwm[2];
    r.motor3_pwm = pwm[3];
    r.idle = idle;
    motor_exp_q.push_back(r);
    if (idle) begin
      w = longint'({47'd0, gains.offset_weight});
      if (w > 65536) w = 65536;
      for (int i = 0; i < 3; i++) begin
        integ_st[i] = 0;
        ang_off[i] = offset_avg(ang_off[i], ang[i], w);
        rate_off[i] = offset_avg(rate_off[i], rt[i], w);
        stick_off[i] = offset_avg(stick_off[i], stk[i], w);
      end
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (tick_valid && tick_ready) begin
        motor_predict(tick);
      end
      if (!tick_valid || tick_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          tick_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          tick <= tick_q.pop_front();
          tick_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode, plus one long hold-off.
  int motors_seen;
  int hold_left;
  bit hold_done;
  int mode_cnt;
  int rx_mode;

  always @(posedge clk) begin
    if (rst) begin
      motor_ready <= 1'b0;
      motors_seen <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      mode_cnt <= 0;
      rx_mode <= 0;
    end else begin
      if (motor_valid && motor_ready) begin
        motors_seen <= motors_seen + 1;
        if (motor_exp_q.size() == 0) begin
          if (errors < 10) $display("ERROR: unexpected transaction %p", motor);
          errors <= errors + 1;
        end else begin
          qacpm_pkg::motor_t e;
          e = motor_exp_q.pop_front();
          if (motor.motor0_pwm !== e.motor0_pwm || motor.motor1_pwm !== e.motor1_pwm ||
              motor.motor2_pwm !== e.motor2_pwm || motor.motor3_pwm !== e.motor3_pwm ||
              motor.idle !== e.idle) begin
            if (errors < 10) begin
              $display("ERROR: result %0d expected m0=%0d m1=%0d m2=%0d m3=%0d idle=%0b",
                       motors_seen, e.motor0_pwm, e.motor1_pwm, e.motor2_pwm,
                       e.motor3_pwm, e.idle);
              $display("       actual m0=%0d m1=%0d m2=%0d m3=%0d idle=%0b",
                       motor.motor0_pwm, motor.motor1_pwm, motor.motor2_pwm,
                       motor.motor3_pwm, motor.idle);
            end
            errors <= errors + 1;
          end
        end
      end
      mode_cnt <= (mode_cnt == 49) ? 0 : mode_cnt + 1;
      if (mode_cnt == 49) rx_mode <= $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        motor_ready <= 1'b0;
      end else if (motors_seen == 300 && !hold_done) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
        motor_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: begin
            motor_ready <= 1'b1;
          end
          1: begin
            motor_ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            motor_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  int stuck_cycles;

  always @(posedge clk) begin
    if (rst || (tick_valid && tick_ready) || (motor_valid && motor_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WD_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic reg_write(qacpm_pkg::reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= qacpm_pkg::ADDR_W'(4 * int'(r));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      qacpm_pkg::REG_ANGLE_GAIN:     gains.angle_gain = v;
      qacpm_pkg::REG_RATE_P_GAIN:    gains.rate_p_gain = v;
      qacpm_pkg::REG_RATE_I_GAIN:    gains.rate_i_gain = v;
      qacpm_pkg::REG_RATE_D_GAIN:    gains.rate_d_gain = v;
      qacpm_pkg::REG_IDLE_THRESHOLD: gains.idle_threshold = v[16:0];
      qacpm_pkg::REG_OFFSET_WEIGHT:  gains.offset_weight = v[16:0];
      qacpm_pkg::REG_PWM_MIN:        gains.pwm_min = v[15:0];
      default:                       gains.pwm_max = v[15:0];
    endcase
  endtask

  task automatic load_gains(logic [31:0] ag, logic [31:0] pg, logic [31:0] ig,
                            logic [31:0] dg, logic [31:0] thr, logic [31:0] wt,
                            logic [31:0] pmin, logic [31:0] pmax);
    reg_write(qacpm_pkg::REG_ANGLE_GAIN, ag);
    reg_write(qacpm_pkg::REG_RATE_P_GAIN, pg);
    reg_write(qacpm_pkg::REG_RATE_I_GAIN, ig);
    reg_write(qacpm_pkg::REG_RATE_D_GAIN, dg);
    reg_write(qacpm_pkg::REG_IDLE_THRESHOLD, thr);
    reg_write(qacpm_pkg::REG_OFFSET_WEIGHT, wt);
    reg_write(qacpm_pkg::REG_PWM_MIN, pmin);
    reg_write(qacpm_pkg::REG_PWM_MAX, pmax);
  endtask

  function automatic int small_val(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic qacpm_pkg::tick_t random_tick();
    qacpm_pkg::tick_t t;
    logic [319:0] raw;
    int kind;
    int span;
    kind = $urandom_range(0, 19);
    span = ($urandom_range(0, 3) == 0) ? 4000000 : 200000;
    if (kind < 2) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      t = raw[304:0];
    end else begin
      t.throttle = (kind < 5) ? 17'($urandom_range(0, 3000)) : 17'($urandom_range(4000, 65536));
      t.stick_roll = small_val(span);
      t.stick_pitch = small_val(span);
      t.stick_yaw = small_val(span);
      t.angle_a = small_val(span);
      t.angle_b = small_val(span);
      t.angle_c = small_val(span);
      t.rate_a = small_val(span);
      t.rate_b = small_val(span);
      t.rate_c = small_val(span);
    end
    return t;
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (tick_q.size() != 0 || tick_valid || motor_exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) tick_q.push_back(random_tick());
    wait_drained();
  endtask

  initial begin
    qacpm_pkg::tick_t t;
    logic signed [31:0] vals[4];
    rst = 1'b1;
    tick_valid = 1'b0;
    tick = '0;
    motor_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    gains = '{32'd285212672, 32'd53687, 32'd604, 32'd251658, 17'd3277, 17'd3277,
              16'd1000, 16'd2000};
    for (int i = 0; i < 3; i++) begin
      integ_st[i] = 0;
      prev_err[i] = 0;
      ang_off[i] = 0;
      rate_off[i] = 0;
      stick_off[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    vals = '{32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd65536};
    foreach (vals[i]) begin
      t = {17'd32768, {9{vals[i]}}};
      tick_q.push_back(t);
    end
    tick_q.push_back({17'd0, {9{32'sd0}}});
    tick_q.push_back({17'd65536, {9{32'sd0}}});
    tick_q.push_back({17'h1ffff, {9{32'sd0}}});
    tick_q.push_back({17'd3276, {9{32'sd100000}}});
    tick_q.push_back({17'd3277, {9{32'sd100000}}});
    tick_q.push_back({17'd0, {9{32'sh7fffffff}}});
    tick_q.push_back({17'd0, {9{32'sh80000000}}});
    tick_q.push_back({17'd40000, 32'sd500000, {8{32'sd0}}});
    tick_q.push_back({17'd40000, 32'sd0, 32'sd500000, {7{32'sd0}}});
    tick_q.push_back({17'd40000, 64'sd0, 32'sd500000, {6{32'sd0}}});
    tick_q.push_back({17'd40000, {3{32'sd0}}, 32'sd300000, 32'sd0, 32'sd0,
                      32'sd0, 32'sd0, -32'sd300000});
    tick_q.push_back({17'd40000, {6{32'sd0}}, 32'sd0, 32'sd900000, 32'sd0});
    wait_drained();
    run_random(300);

    load_gains(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'd0,
               32'h1ffff, 32'd65535, 32'd0);
    run_random(250);

    load_gains(32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65535);
    run_random(200);

    load_gains(32'd16777216, 32'd2000000, 32'd400000, 32'd900000, 32'd20000,
               32'd65536, 32'd1500, 32'd1200);
    run_random(350);

    load_gains($urandom, $urandom, $urandom_range(0, 1000000), $urandom,
               $urandom_range(0, 65536), $urandom_range(0, 131071),
               $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_random(350);

    load_gains(32'd285212672, 32'd53687, 32'd604, 32'd251658, 32'd3277, 32'd3277,
               32'd1000, 32'd2000);
    run_random(430);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/qacpm_pkg.sv
hdl/qacpm_mul.sv
hdl/qacpm_cfg.sv
hdl/quad_attitude_cascade_pid_mixer.sv
tb/sv/tb_quad_attitude_cascade_pid_mixer.sv
